// File: hdl/tev_pkg.sv
// ----------------------------------------------------------------------------
// tev_pkg
// Shared types, widths and codes of the timed event queue.
// ----------------------------------------------------------------------------
package tev_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned TIME_W      = 32;
  localparam int unsigned KIND_W      = 3;
  localparam int unsigned MODE_W      = 3;
  localparam int unsigned USED_W      = 5;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned SECS_W      = 22;
  localparam int unsigned ENTRY_W     = TIME_W + KIND_W;

  localparam int unsigned SECONDS_PER_MINUTE = 60;
  localparam int unsigned POSITION_DELAY     = 60;
  localparam int unsigned INTERVAL_RESET_MIN = 60;

  localparam logic [MODE_W-1:0] MODE_ADD    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TICK   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

  localparam logic [KIND_W-1:0] KIND_POSITION = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PERIODIC = 3'd4;

  localparam logic [CFG_INDEX_W-1:0] CFG_EVENTS_DISABLED   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PERIODIC_INTERVAL = 2'd1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TIME_W-1:0] tstamp;
  } entry_t;

  typedef struct packed {
    logic              events_disabled;
    logic [SECS_W-1:0] interval_secs;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_INS_START,
    ST_INS_SCAN,
    ST_INS_HEAD,
    ST_REMOVE,
    ST_QUERY
  } st_e;

  function automatic idx_t idx_inc(idx_t i);
    return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx_t'(i + 1'b1);
  endfunction

  function automatic idx_t idx_dec(idx_t i);
    return (i == '0) ? IDX_W'(QUEUE_DEPTH - 1) : idx_t'(i - 1'b1);
  endfunction

  // Both operands stay below the depth, so one subtract wraps the sum.
  function automatic idx_t idx_add(idx_t a, cnt_t b);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(a) + (CNT_W + 1)'(b);
    if (s >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
      s = s - (CNT_W + 1)'(QUEUE_DEPTH);
    end
    return idx_t'(s);
  endfunction

endpackage

// File: hdl/tev_ram.sv
// ----------------------------------------------------------------------------
// tev_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tev_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/tev_cfg.sv
// ----------------------------------------------------------------------------
// tev_cfg
// Configuration registers; keeps the periodic interval in seconds.
// ----------------------------------------------------------------------------
module tev_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tev_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [tev_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output tev_pkg::cfg_t                    cfg_o
);
  import tev_pkg::*;

  logic              disabled_q, disabled_d;
  logic [SECS_W-1:0] secs_q, secs_d;
  logic              wr_beat;

  assign cfg_ready_o = 1'b1;
  assign wr_beat     = cfg_valid_i && cfg_ready_o;

  always_comb begin
    disabled_d = disabled_q;
    secs_d     = secs_q;
    if (wr_beat && (cfg_index_i == CFG_EVENTS_DISABLED)) begin
      disabled_d = cfg_data_i[0];
    end
    if (wr_beat && (cfg_index_i == CFG_PERIODIC_INTERVAL)) begin
      secs_d = SECS_W'(cfg_data_i) * SECS_W'(SECONDS_PER_MINUTE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disabled_q <= 1'b0;
      secs_q     <= SECS_W'(INTERVAL_RESET_MIN * SECONDS_PER_MINUTE);
    end else begin
      disabled_q <= disabled_d;
      secs_q     <= secs_d;
    end
  end

  assign cfg_o.events_disabled = disabled_q;
  assign cfg_o.interval_secs   = secs_q;

endmodule

// File: hdl/tev_seq.sv
// ----------------------------------------------------------------------------
// tev_seq
// Sequencer over the circular entry memory: sorted insert, head pop,
// remove-by-kind compaction and periodic query, one entry per cycle.
// ----------------------------------------------------------------------------
module tev_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [tev_pkg::MODE_W-1:0]  mode_i,
  input  logic [tev_pkg::TIME_W-1:0]  now_seconds_i,
  input  logic [tev_pkg::TIME_W-1:0]  event_when_i,
  input  logic [tev_pkg::KIND_W-1:0]  event_kind_i,
  output logic                        out_valid_o,
  output logic                        fired_o,
  output logic [tev_pkg::KIND_W-1:0]  fired_kind_o,
  output logic                        accepted_o,
  output logic                        queue_full_o,
  output logic [tev_pkg::TIME_W-1:0]  next_periodic_time_o,
  output logic [tev_pkg::USED_W-1:0]  entries_used_o,
  input  tev_pkg::cfg_t               cfg_i,
  output logic                        ram_we_o,
  output tev_pkg::idx_t               ram_waddr_o,
  output logic [tev_pkg::ENTRY_W-1:0] ram_wdata_o,
  output tev_pkg::idx_t               ram_raddr_o,
  input  logic [tev_pkg::ENTRY_W-1:0] ram_rdata_i
);
  import tev_pkg::*;

  st_e  state_q, state_d;
  cnt_t occ_q, occ_d;
  idx_t head_q, head_d;
  idx_t rp_q, rp_d;
  idx_t rl_q, rl_d;
  idx_t wp_q, wp_d;
  cnt_t wcnt_q, wcnt_d;
  logic out_valid_q, out_valid_d;

  logic [MODE_W-1:0] mode_q, mode_d;
  logic [TIME_W-1:0] now_q, now_d;
  logic [KIND_W-1:0] kind_q, kind_d;
  logic [TIME_W-1:0] ins_when_q, ins_when_d;
  logic [KIND_W-1:0] ins_kind_q, ins_kind_d;
  logic              fired_q, fired_d;
  logic [KIND_W-1:0] fkind_q, fkind_d;
  logic              acc_q, acc_d;
  logic              full_q, full_d;
  logic [TIME_W-1:0] next_q, next_d;

  entry_t      rd_entry, new_entry, wr_entry;
  logic        add_ok, is_full, head_due, rearm_ok, shift_up, keep, is_periodic, last;
  logic [TIME_W:0] rearm_when;
  idx_t        tail;

  assign rd_entry  = entry_t'(ram_rdata_i);
  assign new_entry = '{kind: ins_kind_q, tstamp: ins_when_q};
  assign add_ok    = (event_when_i != '0) && (event_when_i > now_seconds_i);
  assign is_full   = (occ_q == CNT_W'(QUEUE_DEPTH));
  assign head_due  = !cfg_i.events_disabled && (occ_q != '0) && (rd_entry.tstamp <= now_q);
  assign rearm_when = {1'b0, now_q} + ((rd_entry.kind == KIND_POSITION) ?
                      (TIME_W + 1)'(POSITION_DELAY) : (TIME_W + 1)'(cfg_i.interval_secs));
  assign rearm_ok  = (rd_entry.kind >= KIND_POSITION) && !rearm_when[TIME_W] &&
                     (rearm_when[TIME_W-1:0] > now_q);
  assign shift_up  = (rd_entry.tstamp >= ins_when_q);
  assign keep      = (rd_entry.kind != kind_q);
  assign is_periodic = (rd_entry.kind == KIND_PERIODIC);
  assign last      = ((CNT_W'(rl_q) + CNT_W'(1)) == occ_q);
  assign tail      = idx_add(head_q, cnt_t'(occ_q - 1'b1));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (mode_i)
            MODE_ADD: begin
              if (add_ok && !is_full) state_d = ST_INS_START;
            end
            MODE_TICK:   state_d = ST_TICK;
            MODE_REMOVE: begin
              if (occ_q != '0) state_d = ST_REMOVE;
            end
            MODE_QUERY: begin
              if (occ_q != '0) state_d = ST_QUERY;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_TICK: state_d = (head_due && rearm_ok) ? ST_INS_START : ST_IDLE;
      ST_INS_START: state_d = (occ_q == '0) ? ST_IDLE : ST_INS_SCAN;
      ST_INS_SCAN: begin
        if (!shift_up) state_d = ST_IDLE;
        else if (rl_q == '0) state_d = ST_INS_HEAD;
      end
      ST_INS_HEAD: state_d = ST_IDLE;
      ST_REMOVE: begin
        if (last) state_d = ST_IDLE;
      end
      ST_QUERY: begin
        if (is_periodic || last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    occ_d       = occ_q;
    head_d      = head_q;
    rp_d        = rp_q;
    rl_d        = rl_q;
    wp_d        = wp_q;
    wcnt_d      = wcnt_q;
    out_valid_d = 1'b0;
    mode_d      = mode_q;
    now_d       = now_q;
    kind_d      = kind_q;
    ins_when_d  = ins_when_q;
    ins_kind_d  = ins_kind_q;
    fired_d     = fired_q;
    fkind_d     = fkind_q;
    acc_d       = acc_q;
    full_d      = full_q;
    next_d      = next_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = head_q;
    wr_entry    = new_entry;
    ram_raddr_o = head_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          mode_d  = mode_i;
          now_d   = now_seconds_i;
          kind_d  = event_kind_i;
          fired_d = 1'b0;
          fkind_d = '0;
          acc_d   = 1'b0;
          full_d  = 1'b0;
          next_d  = '0;
          rp_d    = head_q;
          rl_d    = '0;
          wp_d    = head_q;
          wcnt_d  = '0;
          case (mode_i)
            MODE_ADD: begin
              ins_when_d = event_when_i;
              ins_kind_d = event_kind_i;
              if (!add_ok) begin
                out_valid_d = 1'b1;
              end else if (is_full) begin
                full_d      = 1'b1;
                out_valid_d = 1'b1;
              end
            end
            MODE_TICK: ;
            MODE_REMOVE: out_valid_d = (occ_q == '0);
            MODE_QUERY:  out_valid_d = (occ_q == '0);
            MODE_CLEAR: begin
              occ_d       = '0;
              out_valid_d = 1'b1;
            end
            default: out_valid_d = 1'b1;
          endcase
        end
      end
      ST_TICK: begin
        if (head_due) begin
          fired_d    = 1'b1;
          fkind_d    = rd_entry.kind;
          head_d     = idx_inc(head_q);
          occ_d      = cnt_t'(occ_q - 1'b1);
          ins_when_d = rearm_when[TIME_W-1:0];
          ins_kind_d = (rd_entry.kind == KIND_POSITION) ? KIND_POSITION : KIND_PERIODIC;
          out_valid_d = !rearm_ok;
        end else begin
          out_valid_d = 1'b1;
        end
      end
      ST_INS_START: begin
        if (occ_q == '0) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = head_q;
          occ_d       = cnt_t'(occ_q + 1'b1);
          acc_d       = (mode_q == MODE_ADD);
          out_valid_d = 1'b1;
        end else begin
          ram_raddr_o = tail;
          rp_d        = tail;
          rl_d        = idx_t'(occ_q - 1'b1);
        end
      end
      ST_INS_SCAN: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = idx_inc(rp_q);
        if (shift_up) begin
          wr_entry    = rd_entry;
          ram_raddr_o = idx_dec(rp_q);
          rp_d        = idx_dec(rp_q);
          rl_d        = idx_t'(rl_q - 1'b1);
        end else begin
          occ_d       = cnt_t'(occ_q + 1'b1);
          acc_d       = (mode_q == MODE_ADD);
          out_valid_d = 1'b1;
        end
      end
      ST_INS_HEAD: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = head_q;
        occ_d       = cnt_t'(occ_q + 1'b1);
        acc_d       = (mode_q == MODE_ADD);
        out_valid_d = 1'b1;
      end
      ST_REMOVE: begin
        ram_waddr_o = wp_q;
        wr_entry    = rd_entry;
        if (keep) begin
          ram_we_o = 1'b1;
          wp_d     = idx_inc(wp_q);
          wcnt_d   = cnt_t'(wcnt_q + 1'b1);
        end
        if (last) begin
          occ_d       = cnt_t'(wcnt_q + CNT_W'(keep));
          out_valid_d = 1'b1;
        end else begin
          ram_raddr_o = idx_inc(rp_q);
          rp_d        = idx_inc(rp_q);
          rl_d        = idx_t'(rl_q + 1'b1);
        end
      end
      ST_QUERY: begin
        if (is_periodic) begin
          next_d      = rd_entry.tstamp;
          out_valid_d = 1'b1;
        end else if (last) begin
          out_valid_d = 1'b1;
        end else begin
          ram_raddr_o = idx_inc(rp_q);
          rp_d        = idx_inc(rp_q);
          rl_d        = idx_t'(rl_q + 1'b1);
        end
      end
      default: ;
    endcase
  end

  assign ram_wdata_o = wr_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      occ_q       <= '0;
      head_q      <= '0;
      rp_q        <= '0;
      rl_q        <= '0;
      wp_q        <= '0;
      wcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      head_q      <= head_d;
      rp_q        <= rp_d;
      rl_q        <= rl_d;
      wp_q        <= wp_d;
      wcnt_q      <= wcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    now_q      <= now_d;
    kind_q     <= kind_d;
    ins_when_q <= ins_when_d;
    ins_kind_q <= ins_kind_d;
    fired_q    <= fired_d;
    fkind_q    <= fkind_d;
    acc_q      <= acc_d;
    full_q     <= full_d;
    next_q     <= next_d;
  end

  assign busy                 = (state_q != ST_IDLE);
  assign out_valid_o          = out_valid_q;
  assign fired_o              = fired_q;
  assign fired_kind_o         = fkind_q;
  assign accepted_o           = acc_q;
  assign queue_full_o         = full_q;
  assign next_periodic_time_o = next_q;
  assign entries_used_o       = USED_W'(occ_q);

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CNT_W'(QUEUE_DEPTH))
    else $error("occupancy beyond depth");

  a_beat_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (state_q == ST_IDLE))
    else $error("result beat while busy");

  a_acc_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(acc_q && full_q))
    else $error("accepted and full together");

  a_fired_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && fired_q) |-> (mode_q == MODE_TICK))
    else $error("fired outside a tick");

  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> (state_q != ST_IDLE))
    else $error("memory write while idle");

endmodule

// File: hdl/timed_event_queue_core.sv
// ----------------------------------------------------------------------------
// timed_event_queue_core
// Sorted queue of timed events held in a circular entry memory.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its one result shows
// on the result ports for a single cycle, marked by out_valid_o, and cannot
// be held off. A clear, an unknown mode or a refused add answers in the cycle
// after it is taken; a tick pops the due head and may then insert a re-armed
// event; an add shifts entries up from the tail to its slot; remove-by-kind
// and the periodic query walk the entries from the head. The single read
// port of the entry memory is visited one entry per cycle. Pops move the
// head pointer and need no memory traffic; no clearing pass runs after reset.
// ----------------------------------------------------------------------------
module timed_event_queue_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [tev_pkg::MODE_W-1:0]      mode_i,
  input  logic [tev_pkg::TIME_W-1:0]      now_seconds_i,
  input  logic [tev_pkg::TIME_W-1:0]      event_when_i,
  input  logic [tev_pkg::KIND_W-1:0]      event_kind_i,
  output logic                            out_valid_o,
  output logic                            fired_o,
  output logic [tev_pkg::KIND_W-1:0]      fired_kind_o,
  output logic                            accepted_o,
  output logic                            queue_full_o,
  output logic [tev_pkg::TIME_W-1:0]      next_periodic_time_o,
  output logic [tev_pkg::USED_W-1:0]      entries_used_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tev_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [tev_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import tev_pkg::*;

  cfg_t               cfg;
  logic               ram_we;
  idx_t               ram_waddr;
  idx_t               ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  tev_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tev_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tev_seq u_seq (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start                (start),
    .busy                 (busy),
    .mode_i               (mode_i),
    .now_seconds_i        (now_seconds_i),
    .event_when_i         (event_when_i),
    .event_kind_i         (event_kind_i),
    .out_valid_o          (out_valid_o),
    .fired_o              (fired_o),
    .fired_kind_o         (fired_kind_o),
    .accepted_o           (accepted_o),
    .queue_full_o         (queue_full_o),
    .next_periodic_time_o (next_periodic_time_o),
    .entries_used_o       (entries_used_o),
    .cfg_i                (cfg),
    .ram_we_o             (ram_we),
    .ram_waddr_o          (ram_waddr),
    .ram_wdata_o          (ram_wdata),
    .ram_raddr_o          (ram_raddr),
    .ram_rdata_i          (ram_rdata)
  );

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the timed event queue core.
// The bench drives add, tick, remove, query, clear and unknown commands under
// several register settings, with bursty issue timing. A shadow of the sorted
// queue predicts every answer, and each answer is checked field by field
// against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module testbench;
  import tev_pkg::*;

  localparam int unsigned CLK_HALF        = 5;
  localparam int unsigned RESET_CYCLES    = 8;
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned SETTLE_CYCLES   = 24;
  localparam int unsigned ITEMS_PER_PHASE = 290;
  localparam int unsigned PRINT_CAP       = 40;

  localparam logic [MODE_W-1:0] MODE_MAX = {MODE_W{1'b1}};
  localparam logic [KIND_W-1:0] KIND_MAX = {KIND_W{1'b1}};

  localparam logic [KIND_W-1:0] KIND_DAY_PART      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BUS_INIT      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_AFTER_CONNECT = 3'd2;

  typedef struct packed {
    logic              fired;
    logic [KIND_W-1:0] kind;
    logic              accepted;
    logic              full;
    logic [TIME_W-1:0] next_time;
    logic [USED_W-1:0] used;
  } answer_t;

  class event_queue_shadow;
    logic [TIME_W-1:0]     slot_time [QUEUE_DEPTH];
    logic [KIND_W-1:0]     slot_kind [QUEUE_DEPTH];
    int unsigned           held;
    logic                  disabled;
    logic [CFG_DATA_W-1:0] interval_min;
    answer_t               pending_answers[$];
    int unsigned           mismatches;
    int unsigned           answers_seen;

    function new();
      held         = 0;
      disabled     = 1'b0;
      interval_min = CFG_DATA_W'(INTERVAL_RESET_MIN);
      mismatches   = 0;
      answers_seen = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        CFG_EVENTS_DISABLED:   disabled = data[0];
        CFG_PERIODIC_INTERVAL: interval_min = data;
        default: ;
      endcase
    endfunction

    // 1 stored, 0 refused by the time test, -1 no room
    function int place(longint unsigned due, logic [TIME_W-1:0] now,
                       logic [KIND_W-1:0] kind);
      int unsigned pos;
      if (due == 64'd0 || due <= 64'(now) || due > 64'hFFFF_FFFF) begin
        return 0;
      end
      if (held >= QUEUE_DEPTH) begin
        return -1;
      end
      pos = 0;
      while (pos < held && slot_time[pos] < due[TIME_W-1:0]) pos++;
      for (int unsigned j = held; j > pos; j--) begin
        slot_time[j] = slot_time[j-1];
        slot_kind[j] = slot_kind[j-1];
      end
      slot_time[pos] = due[TIME_W-1:0];
      slot_kind[pos] = kind;
      held++;
      return 1;
    endfunction

    function void note_command(logic [MODE_W-1:0] mode, logic [TIME_W-1:0] now,
                               logic [TIME_W-1:0] due, logic [KIND_W-1:0] kind);
      answer_t     a;
      int          status;
      int unsigned w;
      a = '0;
      case (mode)
        MODE_ADD: begin
          status     = place(64'(due), now, kind);
          a.accepted = (status > 0);
          a.full     = (status < 0);
        end
        MODE_TICK: begin
          if (!disabled && held != 0 && slot_time[0] <= now) begin
            a.fired = 1'b1;
            a.kind  = slot_kind[0];
            for (int unsigned j = 1; j < held; j++) begin
              slot_time[j-1] = slot_time[j];
              slot_kind[j-1] = slot_kind[j];
            end
            held--;
            status = 0;
            if (a.kind == KIND_POSITION) begin
              status = place(64'(now) + 64'(POSITION_DELAY), now, KIND_POSITION);
            end else if (a.kind >= KIND_PERIODIC) begin
              status = place(64'(now) + 64'(interval_min) * 64'(SECONDS_PER_MINUTE),
                             now, KIND_PERIODIC);
            end
            a.full = (status < 0);
          end
        end
        MODE_REMOVE: begin
          w = 0;
          for (int unsigned r = 0; r < held; r++) begin
            if (slot_kind[r] != kind) begin
              slot_time[w] = slot_time[r];
              slot_kind[w] = slot_kind[r];
              w++;
            end
          end
          held = w;
        end
        MODE_QUERY: begin
          for (int unsigned i = 0; i < held; i++) begin
            if (slot_kind[i] == KIND_PERIODIC) begin
              a.next_time = slot_time[i];
              break;
            end
          end
        end
        MODE_CLEAR: held = 0;
        default: ;
      endcase
      a.used = USED_W'(held);
      pending_answers.push_back(a);
    endfunction

    task report(string msg);
      if (mismatches < PRINT_CAP) $display("[%0t] MISMATCH %s", $time, msg);
      mismatches++;
    endtask

    task compare(string field, logic [TIME_W-1:0] seen, logic [TIME_W-1:0] want);
      if (seen !== want) begin
        report($sformatf("answer %0d: %s is %0h, expected %0h",
                         answers_seen, field, seen, want));
      end
    endtask

    task check_answer(answer_t got);
      answer_t want;
      answers_seen++;
      if (pending_answers.size() == 0) begin
        report($sformatf("answer %0d arrived with nothing outstanding", answers_seen));
        return;
      end
      want = pending_answers.pop_front();
      compare("fired", TIME_W'(got.fired), TIME_W'(want.fired));
      compare("fired_kind", TIME_W'(got.kind), TIME_W'(want.kind));
      compare("accepted", TIME_W'(got.accepted), TIME_W'(want.accepted));
      compare("queue_full", TIME_W'(got.full), TIME_W'(want.full));
      compare("next_periodic_time", got.next_time, want.next_time);
      compare("entries_used", TIME_W'(got.used), TIME_W'(want.used));
    endtask
  endclass

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   start     = 1'b0;
  logic [MODE_W-1:0]      mode      = '0;
  logic [TIME_W-1:0]      now_s     = '0;
  logic [TIME_W-1:0]      due_s     = '0;
  logic [KIND_W-1:0]      kind      = '0;
  logic                   cfg_valid = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  logic                   busy;
  logic                   out_valid;
  logic                   fired;
  logic [KIND_W-1:0]      fired_kind;
  logic                   accepted;
  logic                   queue_full;
  logic [TIME_W-1:0]      next_periodic;
  logic [USED_W-1:0]      entries_used;
  logic                   cfg_ready;

  event_queue_shadow      board;
  int unsigned            cycles     = 0;
  int unsigned            burst_left = 0;
  bit                     gaps_on    = 1'b1;
  logic [TIME_W-1:0]      wall_now   = '0;

  timed_event_queue_core dut (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .start                (start),
    .busy                 (busy),
    .mode_i               (mode),
    .now_seconds_i        (now_s),
    .event_when_i         (due_s),
    .event_kind_i         (kind),
    .out_valid_o          (out_valid),
    .fired_o              (fired),
    .fired_kind_o         (fired_kind),
    .accepted_o           (accepted),
    .queue_full_o         (queue_full),
    .next_periodic_time_o (next_periodic),
    .entries_used_o       (entries_used),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_o          (cfg_ready),
    .cfg_index_i          (cfg_index),
    .cfg_data_i           (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
      if (start && !busy) board.note_command(mode, now_s, due_s, kind);
      if (out_valid) begin
        board.check_answer({fired, fired_kind, accepted, queue_full,
                            next_periodic, entries_used});
      end
    end
  end

  task automatic idle(int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // hold the beat until taken, then maybe drop start for a gap
  task automatic send(logic [MODE_W-1:0] m, logic [TIME_W-1:0] t_now,
                      logic [TIME_W-1:0] t_due, logic [KIND_W-1:0] k);
    start <= 1'b1;
    mode  <= m;
    now_s <= t_now;
    due_s <= t_due;
    kind  <= k;
    do @(posedge clk); while (busy);
    if (burst_left != 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gaps_on && $urandom_range(0, 3) != 0) idle($urandom_range(1, 20));
    end
  endtask

  task automatic set_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    idle(1);
    while (board.pending_answers.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int unsigned items, logic [TIME_W-1:0] first_now);
    int unsigned       done;
    int unsigned       pick;
    logic [TIME_W-1:0] due;
    done     = 0;
    wall_now = first_now;
    while (done < items) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        // fill past capacity
        for (int unsigned n = 0; n < QUEUE_DEPTH + 2; n++) begin
          send(MODE_ADD, wall_now, wall_now + $urandom_range(1, 900),
               KIND_W'($urandom_range(0, KIND_MAX)));
        end
        done += QUEUE_DEPTH + 2;
      end else begin
        if (pick < 12) begin
          send(MODE_W'($urandom_range(0, MODE_MAX)), $urandom(), $urandom(),
               KIND_W'($urandom_range(0, KIND_MAX)));
        end else if (pick < 14) begin
          send(MODE_CLEAR, wall_now, $urandom(), KIND_W'($urandom_range(0, KIND_MAX)));
        end else if (pick < 20) begin
          send(MODE_REMOVE, $urandom(), $urandom(), KIND_W'($urandom_range(0, KIND_MAX)));
        end else if (pick < 28) begin
          send(MODE_QUERY, $urandom(), $urandom(), KIND_W'($urandom_range(0, KIND_MAX)));
        end else if (pick < 32) begin
          case ($urandom_range(0, 2))
            0:       due = '0;
            1:       due = wall_now;
            default: due = wall_now - $urandom_range(1, 500);
          endcase
          send(MODE_ADD, wall_now, due, KIND_W'($urandom_range(0, KIND_MAX)));
        end else if (pick < 64) begin
          send(MODE_ADD, wall_now, wall_now + $urandom_range(1, 900),
               KIND_W'($urandom_range(0, KIND_MAX)));
        end else begin
          if ($urandom_range(0, 9) == 0) wall_now += $urandom_range(0, 4000);
          else wall_now += $urandom_range(0, 240);
          send(MODE_TICK, wall_now, $urandom(), KIND_W'($urandom_range(0, KIND_MAX)));
        end
        done++;
      end
    end
  endtask

  task automatic run_phase(logic off, logic [CFG_DATA_W-1:0] minutes,
                           logic [TIME_W-1:0] first_now, bit with_gaps);
    set_reg(CFG_EVENTS_DISABLED, CFG_DATA_W'(off));
    set_reg(CFG_PERIODIC_INTERVAL, minutes);
    gaps_on = with_gaps;
    random_phase(ITEMS_PER_PHASE, first_now);
  endtask

  initial begin
    board = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(MODE_QUERY, 32'd0, 32'd0, KIND_DAY_PART);
    send(MODE_TICK, 32'hFFFF_FFFF, 32'd0, KIND_DAY_PART);
    send(MODE_ADD, 32'd100, 32'd0, KIND_PERIODIC);
    send(MODE_ADD, 32'd100, 32'd100, KIND_PERIODIC);
    send(MODE_ADD, 32'd100, 32'd99, KIND_BUS_INIT);
    send(MODE_ADD, 32'd0, 32'hFFFF_FFFF, KIND_PERIODIC);
    send(MODE_ADD, 32'd100, 32'd200, KIND_POSITION);
    send(MODE_ADD, 32'd100, 32'd200, KIND_DAY_PART);
    send(MODE_ADD, 32'd100, 32'd150, KIND_W'(KIND_PERIODIC + 1));
    send(MODE_QUERY, 32'd100, 32'd0, KIND_PERIODIC);
    send(MODE_TICK, 32'd160, 32'd0, KIND_DAY_PART);
    send(MODE_TICK, 32'd199, 32'd0, KIND_DAY_PART);
    send(MODE_TICK, 32'd200, 32'd0, KIND_DAY_PART);
    send(MODE_TICK, 32'd200, 32'd0, KIND_DAY_PART);
    send(MODE_REMOVE, 32'd0, 32'd0, KIND_PERIODIC);
    send(MODE_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, KIND_MAX);
    send(MODE_CLEAR, 32'd0, 32'd0, KIND_DAY_PART);
    send(MODE_ADD, 32'hFFFF_FF00, 32'hFFFF_FFF0, KIND_PERIODIC);
    send(MODE_TICK, 32'hFFFF_FFF0, 32'd0, KIND_DAY_PART);
    send(MODE_ADD, 32'd0, 32'hFFFF_FFC8, KIND_POSITION);
    send(MODE_TICK, 32'hFFFF_FFC8, 32'd0, KIND_DAY_PART);
    set_reg(CFG_PERIODIC_INTERVAL, '0);
    send(MODE_ADD, 32'd0, 32'd1000, KIND_W'(KIND_PERIODIC + 2));
    send(MODE_TICK, 32'd1000, 32'd0, KIND_DAY_PART);
    set_reg(CFG_EVENTS_DISABLED, CFG_DATA_W'(1));
    send(MODE_ADD, 32'd0, 32'd2000, KIND_BUS_INIT);
    send(MODE_TICK, 32'hFFFF_FFFF, 32'd0, KIND_AFTER_CONNECT);
    set_reg(CFG_EVENTS_DISABLED, '0);
    send(MODE_TICK, 32'd2000, 32'd0, KIND_DAY_PART);

    run_phase(1'b0, CFG_DATA_W'(INTERVAL_RESET_MIN), 32'd0, 1'b1);
    run_phase(1'b0, CFG_DATA_W'(1), $urandom(), 1'b1);
    run_phase(1'b0, '0, 32'd1000, 1'b0);
    run_phase(1'b1, CFG_DATA_W'(INTERVAL_RESET_MIN), 32'd5000, 1'b1);
    run_phase(1'b0, {CFG_DATA_W{1'b1}}, 32'hFFF0_0000, 1'b1);
    run_phase(1'b0, CFG_DATA_W'(7), 32'hFFFF_FE00, 1'b1);

    idle(1);
    while (board.pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.pending_answers.size() != 0) begin
      board.report($sformatf("%0d answers never arrived", board.pending_answers.size()));
    end
    if (board.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/tev_pkg.sv
hdl/tev_ram.sv
hdl/tev_cfg.sv
hdl/tev_seq.sv
hdl/timed_event_queue_core.sv
dv/testbench.sv
